/* design/ldm_pkg.sv */
// Shared types, widths and register codes for the lens distortion mapper.
`timescale 1ns / 1ps
`default_nettype none
package ldm_pkg;

    localparam int Q20_W    = 24;   // normalized and distorted coordinates, Q4.20
    localparam int CENTER_W = 16;
    localparam int INV_W    = 25;
    localparam int K_W      = 20;
    localparam int P_W      = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int XX_W     = 48;   // raw square and cross products
    localparam int SQ_W     = 28;   // x2, y2, xy in Q.20
    localparam int R2_W     = 29;
    localparam int R4_W     = 36;
    localparam int R6_W     = 43;
    localparam int F_W      = 47;   // radial factor, Q.20
    localparam int TANG_W   = 48;   // tangential sums, Q.34

    localparam logic signed [Q20_W-1:0] Q20_MAX = 24'sh7F_FFFF;
    localparam logic signed [Q20_W-1:0] Q20_MIN = 24'sh80_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_INV_FOCAL_X,
        CFG_INV_FOCAL_Y,
        CFG_RADIAL_K1,
        CFG_RADIAL_K2,
        CFG_RADIAL_K3,
        CFG_TANGENTIAL
    } t_cfg_idx;

    typedef struct packed {
        logic        [CENTER_W-1:0] center_x;
        logic        [CENTER_W-1:0] center_y;
        logic        [INV_W-1:0]    inv_focal_x;
        logic        [INV_W-1:0]    inv_focal_y;
        logic signed [K_W-1:0]      k1;
        logic signed [K_W-1:0]      k2;
        logic signed [K_W-1:0]      k3;
        logic signed [P_W-1:0]      p1;
        logic signed [P_W-1:0]      p2;
    } t_cfg;

    typedef struct packed {
        logic signed [Q20_W-1:0] x;
        logic signed [Q20_W-1:0] y;
        logic                    sat;
    } t_norm;

    typedef struct packed {
        logic signed [TANG_W-1:0] tx;
        logic signed [TANG_W-1:0] ty;
    } t_tang;

    typedef struct packed {
        logic signed [F_W-1:0]   f;
        logic signed [Q20_W-1:0] x;
        logic signed [Q20_W-1:0] y;
        t_tang                   tang;
        logic                    sat;
    } t_poly;

endpackage
`default_nettype wire

/* design/ldm_pixel_if.sv */
// Pixel coordinate request channel.
`timescale 1ns / 1ps
`default_nettype none
interface ldm_pixel_if #(parameter int PIXEL_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

/* design/ldm_dist_if.sv */
// Distorted coordinate result channel.
`timescale 1ns / 1ps
`default_nettype none
interface ldm_dist_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] dist_x;
    logic signed [23:0] dist_y;
    logic               saturated;

    modport source (output valid, output dist_x, output dist_y, output saturated,
                    input ready);
    modport sink   (input valid, input dist_x, input dist_y, input saturated,
                    output ready);
endinterface
`default_nettype wire

/* design/ldm_normalize.sv */
// Principal point offset and reciprocal focal scaling into Q4.20, two stages.
`timescale 1ns / 1ps
`default_nettype none
module ldm_normalize #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel_x,
    input  logic [PIXEL_BITS-1:0] i_pixel_y,
    input  ldm_pkg::t_cfg         i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ldm_pkg::t_norm         o_norm
);
    import ldm_pkg::*;

    localparam int NS = 2;
    localparam int DW = ((PIXEL_BITS + 4 > CENTER_W) ? PIXEL_BITS + 4 : CENTER_W) + 1;
    localparam int PW = DW + INV_W + 1;
    localparam int QW = PW - 8;
    localparam logic signed [PW-1:0] RND8 = PW'(128);

    logic [NS-1:0]           r_v;
    logic [NS-1:0]           en;
    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic signed [PW-1:0]    n_px;
    logic signed [PW-1:0]    n_py;
    logic signed [PW-1:0]    r_px;
    logic signed [PW-1:0]    r_py;
    logic signed [PW-1:0]    rnd_x;
    logic signed [PW-1:0]    rnd_y;
    logic signed [QW-1:0]    qx;
    logic signed [QW-1:0]    qy;
    logic                    ovf_x;
    logic                    ovf_y;
    t_norm                   n_norm;
    t_norm                   r_norm;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_norm  = r_norm;

    always_comb begin
        dx   = $signed({{(DW-PIXEL_BITS-4){1'b0}}, i_pixel_x, 4'b0000})
             - $signed({{(DW-CENTER_W){1'b0}}, i_cfg.center_x});
        dy   = $signed({{(DW-PIXEL_BITS-4){1'b0}}, i_pixel_y, 4'b0000})
             - $signed({{(DW-CENTER_W){1'b0}}, i_cfg.center_y});
        n_px = dx * $signed({1'b0, i_cfg.inv_focal_x});
        n_py = dy * $signed({1'b0, i_cfg.inv_focal_y});
    end

    always_comb begin
        rnd_x = r_px + RND8;
        rnd_y = r_py + RND8;
        qx    = $signed(rnd_x[PW-1:8]);
        qy    = $signed(rnd_y[PW-1:8]);
        ovf_x = !((&qx[QW-1:Q20_W-1]) || !(|qx[QW-1:Q20_W-1]));
        ovf_y = !((&qy[QW-1:Q20_W-1]) || !(|qy[QW-1:Q20_W-1]));
        n_norm.x   = ovf_x ? (qx[QW-1] ? Q20_MIN : Q20_MAX) : qx[Q20_W-1:0];
        n_norm.y   = ovf_y ? (qy[QW-1] ? Q20_MIN : Q20_MAX) : qy[Q20_W-1:0];
        n_norm.sat = ovf_x || ovf_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        if (en[1]) begin
            r_norm <= n_norm;
        end
    end

endmodule
`default_nettype wire

/* design/ldm_poly.sv */
// Squares, powers of r2, radial factor and tangential sums, nine stages.
`timescale 1ns / 1ps
`default_nettype none
module ldm_poly (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ldm_pkg::t_norm i_norm,
    input  ldm_pkg::t_cfg  i_cfg,
    output logic          o_valid,
    input  logic          i_ready,
    output ldm_pkg::t_poly o_poly
);
    import ldm_pkg::*;

    localparam int NS     = 9;
    localparam int R2SQ_W = 58;
    localparam int K1R2_W = K_W + R2_W;
    localparam int PXY_W  = P_W + SQ_W;
    localparam int A_W    = R2_W + 1;
    localparam int PA_W   = P_W + A_W;
    localparam int R4R2_W = 64;
    localparam int K2R4_W = K_W + R4_W;
    localparam int S12_W  = K2R4_W + 1;
    localparam int K3P_W  = K_W + 22;
    localparam int SUM_W  = 62;

    localparam logic signed [XX_W-1:0]   RND_XX   = XX_W'(2**19);
    localparam logic signed [R2SQ_W-1:0] RND_R2SQ = R2SQ_W'(2**19);
    localparam logic signed [R4R2_W-1:0] RND_R4R2 = R4R2_W'(2**19);
    localparam logic signed [SUM_W-1:0]  RND_SUM  = SUM_W'(2**15);
    localparam logic signed [F_W-1:0]    ONE_Q20  = F_W'(2**20);

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    t_norm r_c [0:NS-1];
    t_tang r_tang [3:NS-1];

    // stage 0
    logic signed [XX_W-1:0]   r_xx, r_yy, r_xy;
    // stage 1
    logic signed [XX_W-1:0]   rnd_xx, rnd_yy, rnd_xy;
    logic signed [SQ_W-1:0]   n_x2, n_y2, n_xy1;
    logic signed [SQ_W-1:0]   r_x2, r_y2, r_xy1;
    logic signed [R2_W-1:0]   r_r2 [1:3];
    // stage 2
    logic signed [A_W-1:0]    a_x, a_y;
    logic signed [R2SQ_W-1:0] r_r2sq;
    logic signed [K1R2_W-1:0] r_k1r2 [2:4];
    logic signed [PXY_W-1:0]  r_p1xy, r_p2xy;
    logic signed [PA_W-1:0]   r_p2a, r_p1b;
    // stage 3
    logic signed [R2SQ_W-1:0] rnd_r2sq;
    logic signed [R4_W-1:0]   r_r4;
    t_tang                    n_tang;
    // stage 4
    logic signed [R4R2_W-1:0] r_r4r2;
    logic signed [K2R4_W-1:0] r_k2r4;
    // stage 5
    logic signed [R4R2_W-1:0] rnd_r4r2;
    logic signed [R6_W-1:0]   r_r6;
    logic signed [S12_W-1:0]  r_s12 [5:6];
    // stage 6
    logic signed [K3P_W-1:0]  r_k3hi, r_k3lo;
    // stage 7
    logic signed [SUM_W-1:0]  r_sum;
    // stage 8
    logic signed [SUM_W-1:0]  rnd_sum;
    logic signed [F_W-1:0]    r_f;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    always_comb begin
        o_poly.f    = r_f;
        o_poly.x    = r_c[NS-1].x;
        o_poly.y    = r_c[NS-1].y;
        o_poly.tang = r_tang[NS-1];
        o_poly.sat  = r_c[NS-1].sat;
    end

    always_comb begin
        rnd_xx   = r_xx + RND_XX;
        rnd_yy   = r_yy + RND_XX;
        rnd_xy   = r_xy + RND_XX;
        n_x2     = $signed(rnd_xx[XX_W-1:20]);
        n_y2     = $signed(rnd_yy[XX_W-1:20]);
        n_xy1    = $signed(rnd_xy[XX_W-1:20]);
        a_x      = A_W'(r_r2[1]) + (A_W'(r_x2) <<< 1);
        a_y      = A_W'(r_r2[1]) + (A_W'(r_y2) <<< 1);
        rnd_r2sq = r_r2sq + RND_R2SQ;
        n_tang.tx = (TANG_W'(r_p1xy) <<< 1) + TANG_W'(r_p2a);
        n_tang.ty = TANG_W'(r_p1b) + (TANG_W'(r_p2xy) <<< 1);
        rnd_r4r2 = r_r4r2 + RND_R4R2;
        rnd_sum  = r_sum + RND_SUM;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // carried coordinates and flags
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_c[0] <= i_norm;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_c[k] <= r_c[k-1];
            end
        end
        if (en[3]) begin
            r_tang[3] <= n_tang;
        end
        for (int k = 4; k < NS; k++) begin
            if (en[k]) begin
                r_tang[k] <= r_tang[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_xx <= i_norm.x * i_norm.x;
            r_yy <= i_norm.y * i_norm.y;
            r_xy <= i_norm.x * i_norm.y;
        end
        if (en[1]) begin
            r_x2    <= n_x2;
            r_y2    <= n_y2;
            r_xy1   <= n_xy1;
            r_r2[1] <= R2_W'(n_x2) + R2_W'(n_y2);
        end
        if (en[2]) begin
            r_r2sq    <= r_r2[1] * r_r2[1];
            r_k1r2[2] <= i_cfg.k1 * r_r2[1];
            r_p1xy    <= i_cfg.p1 * r_xy1;
            r_p2xy    <= i_cfg.p2 * r_xy1;
            r_p2a     <= i_cfg.p2 * a_x;
            r_p1b     <= i_cfg.p1 * a_y;
            r_r2[2]   <= r_r2[1];
        end
        if (en[3]) begin
            r_r4      <= $signed(rnd_r2sq[R4_W+19:20]);
            r_k1r2[3] <= r_k1r2[2];
            r_r2[3]   <= r_r2[2];
        end
        if (en[4]) begin
            r_r4r2    <= r_r4 * r_r2[3];
            r_k2r4    <= i_cfg.k2 * r_r4;
            r_k1r2[4] <= r_k1r2[3];
        end
        if (en[5]) begin
            r_r6     <= $signed(rnd_r4r2[R6_W+19:20]);
            r_s12[5] <= S12_W'(r_k1r2[4]) + S12_W'(r_k2r4);
        end
        if (en[6]) begin
            // split r6 so each product stays narrow
            r_k3hi   <= i_cfg.k3 * $signed(r_r6[R6_W-1:21]);
            r_k3lo   <= i_cfg.k3 * $signed({1'b0, r_r6[20:0]});
            r_s12[6] <= r_s12[5];
        end
        if (en[7]) begin
            r_sum <= SUM_W'(r_s12[6]) + (SUM_W'(r_k3hi) <<< 21) + SUM_W'(r_k3lo);
        end
        if (en[8]) begin
            r_f <= ONE_Q20 + F_W'($signed(rnd_sum[SUM_W-1:16]));
        end
    end

    a_r2_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> !r_r2[1][R2_W-1])
        else $error("r2 went negative");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && !i_ready |=> r_v[NS-1])
        else $error("stalled result dropped in polynomial stage");

endmodule
`default_nettype wire

/* design/ldm_combine.sv */
// Radial factor times coordinate plus tangential term, rounding and clamp.
`timescale 1ns / 1ps
`default_nettype none
module ldm_combine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  ldm_pkg::t_poly             i_poly,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [ldm_pkg::Q20_W-1:0] o_dist_x,
    output logic signed [ldm_pkg::Q20_W-1:0] o_dist_y,
    output logic                      o_saturated
);
    import ldm_pkg::*;

    localparam int NS     = 4;
    localparam int FH_W   = F_W - 24;
    localparam int HI_W   = FH_W + Q20_W;
    localparam int LO_W   = 25 + Q20_W;
    localparam int PROD_W = 71;
    localparam int Q_W    = PROD_W - 20;

    localparam logic signed [PROD_W-1:0] LIM     = PROD_W'(1) <<< 61;
    localparam logic signed [PROD_W-1:0] LIM_NEG = -LIM;
    localparam logic signed [PROD_W-1:0] RND20   = PROD_W'(2**19);

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    logic signed [FH_W-1:0]   fh;
    logic signed [24:0]       fl;
    logic signed [HI_W-1:0]   r_hx, r_hy;
    logic signed [LO_W-1:0]   r_lx, r_ly;
    t_tang                    r_tang [0:1];
    logic                     r_sat [0:2];
    logic signed [PROD_W-1:0] r_prodx, r_prody;
    logic signed [PROD_W-1:0] sum_x, sum_y;
    logic signed [Q_W-1:0]    r_qx, r_qy;
    logic                     r_ovpx, r_ovnx, r_ovpy, r_ovny;
    logic                     ovf_x, ovf_y;
    logic signed [Q20_W-1:0]  n_dx, n_dy;
    logic                     n_sat;
    logic signed [Q20_W-1:0]  r_dx, r_dy;
    logic                     r_sat_out;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready     = en[0];
    assign o_valid     = r_v[NS-1];
    assign o_dist_x    = r_dx;
    assign o_dist_y    = r_dy;
    assign o_saturated = r_sat_out;

    always_comb begin
        fh    = $signed(i_poly.f[F_W-1:24]);
        fl    = $signed({1'b0, i_poly.f[23:0]});
        sum_x = r_prodx + (PROD_W'(r_tang[1].tx) <<< 6) + RND20;
        sum_y = r_prody + (PROD_W'(r_tang[1].ty) <<< 6) + RND20;
        ovf_x = !((&r_qx[Q_W-1:Q20_W-1]) || !(|r_qx[Q_W-1:Q20_W-1]));
        ovf_y = !((&r_qy[Q_W-1:Q20_W-1]) || !(|r_qy[Q_W-1:Q20_W-1]));
        // huge radial product wins over the rounded sum
        if (r_ovpx) begin
            n_dx = Q20_MAX;
        end else if (r_ovnx) begin
            n_dx = Q20_MIN;
        end else if (ovf_x) begin
            n_dx = r_qx[Q_W-1] ? Q20_MIN : Q20_MAX;
        end else begin
            n_dx = r_qx[Q20_W-1:0];
        end
        if (r_ovpy) begin
            n_dy = Q20_MAX;
        end else if (r_ovny) begin
            n_dy = Q20_MIN;
        end else if (ovf_y) begin
            n_dy = r_qy[Q_W-1] ? Q20_MIN : Q20_MAX;
        end else begin
            n_dy = r_qy[Q20_W-1:0];
        end
        n_sat = r_sat[2] || r_ovpx || r_ovnx || r_ovpy || r_ovny || ovf_x || ovf_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_hx      <= fh * i_poly.x;
            r_lx      <= fl * i_poly.x;
            r_hy      <= fh * i_poly.y;
            r_ly      <= fl * i_poly.y;
            r_tang[0] <= i_poly.tang;
            r_sat[0]  <= i_poly.sat;
        end
        if (en[1]) begin
            r_prodx   <= (PROD_W'(r_hx) <<< 24) + PROD_W'(r_lx);
            r_prody   <= (PROD_W'(r_hy) <<< 24) + PROD_W'(r_ly);
            r_tang[1] <= r_tang[0];
            r_sat[1]  <= r_sat[0];
        end
        if (en[2]) begin
            r_ovpx   <= r_prodx > LIM;
            r_ovnx   <= r_prodx < LIM_NEG;
            r_ovpy   <= r_prody > LIM;
            r_ovny   <= r_prody < LIM_NEG;
            r_qx     <= $signed(sum_x[PROD_W-1:20]);
            r_qy     <= $signed(sum_y[PROD_W-1:20]);
            r_sat[2] <= r_sat[1];
        end
        if (en[3]) begin
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_sat_out <= n_sat;
        end
    end

    a_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> $onehot0({r_ovpx, r_ovnx}) && $onehot0({r_ovpy, r_ovny}))
        else $error("product overflow flagged in both directions");

    a_blocked_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v) && !i_ready)
        else $error("combine stage refused a request with room left");

endmodule
`default_nettype wire

/* design/lens_distortion_mapper_core.sv */
// Top level of the Brown-Conrady lens distortion mapper with its register file.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-------------------------------------------
//  i_pix     | in  | valid / ready    | pixel_x, pixel_y (PIXEL_BITS, unsigned)
//  o_dist    | out | valid / ready    | dist_x, dist_y (Q4.20), saturated
//  cfg       | in  | i_cfg_we only    | i_cfg_idx (3 bits), i_cfg_wdata (32 bits)
//
// One request per clock unless o_dist.ready stalls the pipe; each result passes
// through the fifteen register stages (2 normalize, 9 polynomial, 4 combine).
// Every stage carries a valid bit and loads when empty or when its content moves
// on, so bubbles close up and a stalled result holds in the output register.
// i_pix.ready drops only once every stage is full and o_dist.ready is low.
// Synchronous reset clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module lens_distortion_mapper_core #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ldm_pixel_if.sink                     i_pix,
    ldm_dist_if.source                    o_dist,
    input  logic                          i_cfg_we,
    input  logic [ldm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ldm_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import ldm_pkg::*;

    t_cfg  r_cfg;
    t_norm norm;
    t_poly poly;
    logic  norm_valid, norm_ready;
    logic  poly_valid, poly_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= '0;
            r_cfg.center_y    <= '0;
            r_cfg.inv_focal_x <= INV_W'(2**24);
            r_cfg.inv_focal_y <= INV_W'(2**24);
            r_cfg.k1          <= '0;
            r_cfg.k2          <= '0;
            r_cfg.k3          <= '0;
            r_cfg.p1          <= '0;
            r_cfg.p2          <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_wdata[CENTER_W-1:0];
                CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_wdata[CENTER_W-1:0];
                CFG_INV_FOCAL_X: r_cfg.inv_focal_x <= i_cfg_wdata[INV_W-1:0];
                CFG_INV_FOCAL_Y: r_cfg.inv_focal_y <= i_cfg_wdata[INV_W-1:0];
                CFG_RADIAL_K1:   r_cfg.k1          <= i_cfg_wdata[K_W-1:0];
                CFG_RADIAL_K2:   r_cfg.k2          <= i_cfg_wdata[K_W-1:0];
                CFG_RADIAL_K3:   r_cfg.k3          <= i_cfg_wdata[K_W-1:0];
                CFG_TANGENTIAL: begin
                    r_cfg.p1 <= i_cfg_wdata[P_W-1:0];
                    r_cfg.p2 <= i_cfg_wdata[2*P_W-1:P_W];
                end
                default: ;
            endcase
        end
    end

    ldm_normalize #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pix.valid),
        .o_ready   (i_pix.ready),
        .i_pixel_x (i_pix.pixel_x),
        .i_pixel_y (i_pix.pixel_y),
        .i_cfg     (r_cfg),
        .o_valid   (norm_valid),
        .i_ready   (norm_ready),
        .o_norm    (norm)
    );

    ldm_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (norm_valid),
        .o_ready (norm_ready),
        .i_norm  (norm),
        .i_cfg   (r_cfg),
        .o_valid (poly_valid),
        .i_ready (poly_ready),
        .o_poly  (poly)
    );

    ldm_combine u_comb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (poly_valid),
        .o_ready     (poly_ready),
        .i_poly      (poly),
        .o_valid     (o_dist.valid),
        .i_ready     (o_dist.ready),
        .o_dist_x    (o_dist.dist_x),
        .o_dist_y    (o_dist.dist_y),
        .o_saturated (o_dist.saturated)
    );

endmodule
`default_nettype wire

/* tb/lens_distortion_mapper_checker.sv */
// Checker: predicts the distorted coordinate of every accepted pixel and compares results.
`timescale 1ns / 1ps
module lens_distortion_mapper_checker #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ldm_pixel_if                          i_pix,
    ldm_dist_if                           i_dist,
    input  logic                          i_cfg_we,
    input  logic [ldm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ldm_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ldm_pkg::*;

    typedef logic signed [127:0] t_acc;

    typedef struct packed {
        logic signed [Q20_W-1:0] dist_x;
        logic signed [Q20_W-1:0] dist_y;
        logic                    saturated;
    } t_dist;

    t_cfg  lens_cfg;
    t_dist distorted_q[$];
    int    mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    function automatic t_acc round_half_up(input t_acc v, input int s);
        return (v + (t_acc'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_acc clamp_q20(input t_acc v);
        if (v > t_acc'(Q20_MAX)) return t_acc'(Q20_MAX);
        if (v < t_acc'(Q20_MIN)) return t_acc'(Q20_MIN);
        return v;
    endfunction

    // Unclamped normalized coordinate, Q.20
    function automatic t_acc norm_coord(input logic [PIXEL_BITS-1:0] pix,
                                        input logic [CENTER_W-1:0] center,
                                        input logic [INV_W-1:0] inv);
        t_acc pix_q4;
        t_acc center_q4;
        t_acc inv_q24;
        pix_q4    = {pix, 4'b0000};
        center_q4 = center;
        inv_q24   = inv;
        return round_half_up((pix_q4 - center_q4) * inv_q24, 8);
    endfunction

    // Radial factor times coordinate plus tangential term, back to Q.20 (unclamped)
    function automatic t_acc apply_distortion(input t_acc f, input t_acc n, input t_acc tang);
        t_acc prod;
        t_acc bound;
        prod  = f * n;
        bound = t_acc'(1) <<< 61;
        // past the bound only the sign matters; the clamp saturates the raw product
        if (prod > bound || prod < -bound) return prod;
        return round_half_up(prod + tang * 64, 20);
    endfunction

    function automatic t_dist predict_distortion(input t_cfg c,
                                                 input logic [PIXEL_BITS-1:0] px,
                                                 input logic [PIXEL_BITS-1:0] py);
        t_acc  nx_raw, ny_raw, x, y, x2, y2, xy, r2, r4, r6;
        t_acc  k1, k2, k3, p1, p2, f, tx, ty, dx_raw, dy_raw, dx, dy;
        t_dist res;
        nx_raw = norm_coord(px, c.center_x, c.inv_focal_x);
        ny_raw = norm_coord(py, c.center_y, c.inv_focal_y);
        x = clamp_q20(nx_raw);
        y = clamp_q20(ny_raw);

        x2 = round_half_up(x * x, 20);
        y2 = round_half_up(y * y, 20);
        xy = round_half_up(x * y, 20);
        r2 = x2 + y2;
        r4 = round_half_up(r2 * r2, 20);
        r6 = round_half_up(r4 * r2, 20);

        k1 = c.k1;
        k2 = c.k2;
        k3 = c.k3;
        p1 = c.p1;
        p2 = c.p2;
        f  = (t_acc'(1) <<< 20) + round_half_up(k1 * r2 + k2 * r4 + k3 * r6, 16);
        tx = 2 * p1 * xy + p2 * (r2 + 2 * x2);
        ty = p1 * (r2 + 2 * y2) + 2 * p2 * xy;

        dx_raw = apply_distortion(f, x, tx);
        dy_raw = apply_distortion(f, y, ty);
        dx = clamp_q20(dx_raw);
        dy = clamp_q20(dy_raw);

        res.dist_x    = dx[Q20_W-1:0];
        res.dist_y    = dy[Q20_W-1:0];
        res.saturated = (x != nx_raw) || (y != ny_raw) || (dx != dx_raw) || (dy != dy_raw);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_dist want;
        t_dist got;
        if (!i_rst_n) begin
            lens_cfg             = '0;
            lens_cfg.inv_focal_x = 25'h100_0000;
            lens_cfg.inv_focal_y = 25'h100_0000;
            distorted_q.delete();
        end else begin
            // predict with the settings in force before any write at this edge
            if (i_pix.valid && i_pix.ready) begin
                distorted_q.insert(distorted_q.size(),
                                   predict_distortion(lens_cfg, i_pix.pixel_x,
                                                      i_pix.pixel_y));
            end
            if (i_dist.valid && i_dist.ready) begin
                got.dist_x    = i_dist.dist_x;
                got.dist_y    = i_dist.dist_y;
                got.saturated = i_dist.saturated;
                if (distorted_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("[%0t] result with no request pending: x=%0d y=%0d sat=%0b",
                                 $realtime, got.dist_x, got.dist_y, got.saturated);
                    mismatches++;
                end else begin
                    want = distorted_q.pop_front();
                    if (got.dist_x !== want.dist_x || got.dist_y !== want.dist_y ||
                        got.saturated !== want.saturated) begin
                        if (mismatches < 10)
                            $display({"[%0t] mismatch: expected x=%0d y=%0d sat=%0b,",
                                      " got x=%0d y=%0d sat=%0b"},
                                     $realtime, want.dist_x, want.dist_y, want.saturated,
                                     got.dist_x, got.dist_y, got.saturated);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CENTER_X:    lens_cfg.center_x    = i_cfg_wdata[CENTER_W-1:0];
                    CFG_CENTER_Y:    lens_cfg.center_y    = i_cfg_wdata[CENTER_W-1:0];
                    CFG_INV_FOCAL_X: lens_cfg.inv_focal_x = i_cfg_wdata[INV_W-1:0];
                    CFG_INV_FOCAL_Y: lens_cfg.inv_focal_y = i_cfg_wdata[INV_W-1:0];
                    CFG_RADIAL_K1:   lens_cfg.k1          = i_cfg_wdata[K_W-1:0];
                    CFG_RADIAL_K2:   lens_cfg.k2          = i_cfg_wdata[K_W-1:0];
                    CFG_RADIAL_K3:   lens_cfg.k3          = i_cfg_wdata[K_W-1:0];
                    CFG_TANGENTIAL: begin
                        lens_cfg.p1 = i_cfg_wdata[P_W-1:0];
                        lens_cfg.p2 = i_cfg_wdata[2*P_W-1:P_W];
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= distorted_q.size();
    end

endmodule

/* tb/lens_distortion_mapper_core_tb.sv */
// Testbench top: drives pixel requests and register writes into the lens distortion mapper.
`timescale 1ns / 1ps
module lens_distortion_mapper_core_tb;
    import ldm_pkg::*;

    localparam int PIXEL_BITS     = 12;
    localparam int PIX_MAX        = (1 << PIXEL_BITS) - 1;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 235;
    localparam int SETTLE_CYCLES  = 30;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    int                   fail_count;
    int                   pending;
    int                   burst_left = 0;
    int                   cur_cx     = 0;
    int                   cur_cy     = 0;
    bit                   flush_all  = 1'b0;

    ldm_pixel_if #(.PIXEL_BITS(PIXEL_BITS)) pix_ch ();
    ldm_dist_if                             dist_ch ();

    lens_distortion_mapper_core #(.PIXEL_BITS(PIXEL_BITS)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_ch),
        .o_dist     (dist_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    lens_distortion_mapper_checker #(.PIXEL_BITS(PIXEL_BITS)) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix       (pix_ch),
        .i_dist      (dist_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int clamp_pixel(input int v);
        if (v < 0) return 0;
        if (v > PIX_MAX) return PIX_MAX;
        return v;
    endfunction

    // Send one request; bursts of random length with random gaps in between
    task automatic send_pixel(input int px, input int py);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_ch.valid   <= 1'b1;
        pix_ch.pixel_x <= PIXEL_BITS'(px);
        pix_ch.pixel_y <= PIXEL_BITS'(py);
        do @(posedge clk); while (!pix_ch.ready);
    endtask

    task automatic send_random_pixel();
        int px;
        int py;
        if ($urandom_range(0, 9) < 3) begin
            px = clamp_pixel(cur_cx / 16 + rand_signed(200));
            py = clamp_pixel(cur_cy / 16 + rand_signed(200));
        end else begin
            px = $urandom_range(0, PIX_MAX);
            py = $urandom_range(0, PIX_MAX);
        end
        send_pixel(px, py);
    endtask

    // Hold requests off until every expected result has arrived
    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        burst_left = 0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
    endtask

    task automatic load_settings(input int cx, input int cy, input int ifx, input int ify,
                                 input int k1, input int k2, input int k3,
                                 input int p1, input int p2);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_INV_FOCAL_X, ifx);
        write_reg(CFG_INV_FOCAL_Y, ify);
        write_reg(CFG_RADIAL_K1, k1);
        write_reg(CFG_RADIAL_K2, k2);
        write_reg(CFG_RADIAL_K3, k3);
        write_reg(CFG_TANGENTIAL, {16'(p2), 16'(p1)});
        cfg_we <= 1'b0;
        cur_cx = cx & 16'hFFFF;
        cur_cy = cy & 16'hFFFF;
    endtask

    task automatic load_random_settings(input bit wild);
        if (wild) begin
            load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 32'h1FF_FFFF), $urandom_range(0, 32'h1FF_FFFF),
                          rand_signed(524288), rand_signed(524288), rand_signed(524288),
                          rand_signed(32768), rand_signed(32768));
        end else begin
            load_settings($urandom_range(24000, 40000), $urandom_range(16000, 32000),
                          $urandom_range(4000, 80000), $urandom_range(4000, 80000),
                          rand_signed(32768), rand_signed(16384), rand_signed(4096),
                          rand_signed(400), rand_signed(400));
        end
    endtask

    // Receiver: ready pattern switches between free-running, random, sparse and long stalls
    initial begin : receiver
        int mode;
        int mode_left;
        int tick;
        logic take;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        dist_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(100, 400);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       take = 1'b1;
                1:       take = ($urandom_range(0, 3) != 0);
                2:       take = (tick % 4 == 0);
                default: take = (tick % 32 >= 20);
            endcase
            dist_ch.ready <= take | flush_all;
        end
    end

    initial begin : stimulus
        pix_ch.valid   = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unit reciprocals saturate almost every normalized value
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(0, PIX_MAX);
        send_pixel(PIX_MAX, 0);

        // a plausible lens: center at (2048, 1536), focal length about 1000 px
        drain_results();
        load_settings(2048 * 16, 1536 * 16, 16777, 16777, -19661, 6554, -655, 16, -16);
        send_pixel(2048, 1536);
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(2048, 0);
        send_pixel(0, 1536);
        send_pixel(PIX_MAX, 1536);
        send_pixel(2048, PIX_MAX);

        // reciprocal above 1.0 and largest coefficients: huge radial product
        drain_results();
        load_settings(0, 0, 32'h1FF_FFFF, 0, 524287, 524287, 524287, 32767, 32767);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(1, 0);
        send_pixel(0, 0);
        send_pixel(PIX_MAX, 0);

        drain_results();
        load_settings(65535, 65535, 1 << 24, 1 << 24, -524288, -524288, -524288,
                      -32768, -32768);
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(PIX_MAX, 0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            load_random_settings(phase % 4 == 3 || $urandom_range(0, 4) == 0);
            repeat (PHASE_ITEMS) send_random_pixel();
        end

        flush_all = 1'b1;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 8);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
